@@ src/gea_pkg.sv @@
// ----------------------------------------------------------------------------
// gea_pkg
// Shared types and constants for the geared encoder angle tracker.
// ----------------------------------------------------------------------------
package gea_pkg;

  // field widths
  localparam int ANGLE_W = 13;
  localparam int CUR_W   = 16;
  localparam int SHAFT_W = 15;
  localparam int THR_W   = 14;
  localparam int RATIO_W = 8;
  localparam int TURN_W  = 8;
  localparam int PREV_W  = 13;
  localparam int CFG_W   = 14;

  // configuration register indexes
  typedef enum logic {
    REG_WRAP_THRESHOLD = 1'b0,
    REG_GEAR_RATIO     = 1'b1
  } cfg_reg_t;

  // reset value of the wrap threshold: 1200 counts short of one turn
  localparam int WRAP_MARGIN           = 1200;
  localparam int ENCODER_COUNTS        = 8192;
  localparam logic [THR_W-1:0] WRAP_THRESHOLD_RESET = THR_W'(WRAP_MARGIN - ENCODER_COUNTS);

  // wrap detector verdict
  typedef enum logic [1:0] {
    WRAP_NONE = 2'b00,
    WRAP_FWD  = 2'b01,
    WRAP_BWD  = 2'b10
  } wrap_dir_t;

endpackage

@@ src/gea_if.sv @@
// ----------------------------------------------------------------------------
// gea_if
// Valid/ready channels for feedback samples and tracked shaft results.
// ----------------------------------------------------------------------------
interface gea_in_if;
  logic                               valid;
  logic                               ready;
  logic        [gea_pkg::ANGLE_W-1:0] angle_code;
  logic signed [gea_pkg::CUR_W-1:0]   current_code;

  modport source (output valid, output angle_code, output current_code, input ready);
  modport sink   (input valid, input angle_code, input current_code, output ready);
endinterface

interface gea_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [gea_pkg::SHAFT_W-1:0] shaft_angle;
  logic signed [gea_pkg::CUR_W-1:0]   motor_current;

  modport source (output valid, output shaft_angle, output motor_current, input ready);
  modport sink   (input valid, input shaft_angle, input motor_current, output ready);
endinterface

@@ src/gea_wrap.sv @@
// ----------------------------------------------------------------------------
// gea_wrap
// Wrap detector: compares the step between two samples to a signed threshold.
// ----------------------------------------------------------------------------
module gea_wrap #(
  parameter int W = 13
) (
  input  logic [W-1:0]              now_val,
  input  logic [W-1:0]              before_val,
  input  logic [gea_pkg::THR_W-1:0] threshold,
  output gea_pkg::wrap_dir_t        dir
);

  localparam int CW = W + 2;

  logic signed [CW-1:0] d_fwd;
  logic signed [CW-1:0] d_bwd;
  logic signed [CW-1:0] thr_ext;

  // differences in both directions, wide enough never to overflow
  assign d_fwd   = {2'b00, now_val} - {2'b00, before_val};
  assign d_bwd   = {2'b00, before_val} - {2'b00, now_val};
  assign thr_ext = {{(CW-gea_pkg::THR_W){threshold[gea_pkg::THR_W-1]}}, threshold};

  // forward test takes priority when both hold
  always_comb begin
    if (d_fwd < thr_ext) begin
      dir = gea_pkg::WRAP_FWD;
    end else if (d_bwd < thr_ext) begin
      dir = gea_pkg::WRAP_BWD;
    end else begin
      dir = gea_pkg::WRAP_NONE;
    end
  end

endmodule

@@ src/gea_div.sv @@
// ----------------------------------------------------------------------------
// gea_div
// Restoring divider, one quotient bit per cycle, 8-bit divisor.
// ----------------------------------------------------------------------------
module gea_div #(
  parameter int DW = 21
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DW-1:0]               dividend,
  input  logic [gea_pkg::RATIO_W-1:0] divisor,
  output logic                        done,
  output logic [DW-1:0]               quotient
);

  localparam int RW    = gea_pkg::RATIO_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    q_r;
  logic [RW-1:0]    rem_r;
  logic [RW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [RW:0]      rem_sh;
  logic [RW:0]      rem_sub;
  logic             fits;

  // shift next dividend bit into the partial remainder and trial-subtract
  assign rem_sh  = {rem_r, q_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign fits    = rem_sh >= {1'b0, dvs_r};

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= CNT_W'(DW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
        q_r   <= {q_r[DW-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ src/geared_encoder_angle_tracker_core.sv @@
// ----------------------------------------------------------------------------
// geared_encoder_angle_tracker_core
// Multi-turn encoder unwrap through a gear ratio, with shaft-angle wrap marking.
// ----------------------------------------------------------------------------
// Each item is one motor feedback sample. An encoder wrap steps a turn index
// modulo the gear ratio; the shaft angle is (angle + COUNTS_PER_TURN * turn)
// divided by the ratio, plus or minus one turn on the sample where that angle
// wraps. The dividend is DW bits wide (21 bits at the default COUNTS_PER_TURN),
// and the restoring divider produces one quotient bit per cycle. The result
// sits in an output register, so the next item is accepted while it waits to
// be taken. Writing gear_ratio clears the turn index.
// ----------------------------------------------------------------------------
module geared_encoder_angle_tracker_core (
  input  logic                      clk,
  input  logic                      rst_n,
  gea_in_if.sink                    in_ch,
  gea_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [gea_pkg::CFG_W-1:0] cfg_data
);

  localparam int COUNTS_PER_TURN = gea_pkg::ENCODER_COUNTS;
  localparam int TURN_MAX = (1 << gea_pkg::RATIO_W) - 2;
  localparam int DIV_MAX  = (1 << gea_pkg::ANGLE_W) - 1 + COUNTS_PER_TURN * TURN_MAX;
  localparam int DW       = $clog2(DIV_MAX + 1);
  localparam logic [DW-1:0] CPT_DW = DW'(COUNTS_PER_TURN);
  localparam logic [gea_pkg::SHAFT_W-1:0] CPT_SH = gea_pkg::SHAFT_W'(COUNTS_PER_TURN);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_POST
  } state_t;

  state_t                             state_r;
  logic [gea_pkg::THR_W-1:0]          thr_r;
  logic [gea_pkg::RATIO_W-1:0]        ratio_r;
  logic [gea_pkg::ANGLE_W-1:0]        prev_angle_r;
  logic [gea_pkg::TURN_W-1:0]         turn_r;
  logic [gea_pkg::PREV_W-1:0]         prev_shaft_r;
  logic signed [gea_pkg::CUR_W-1:0]   cur_r;
  logic                               out_valid_r;
  logic signed [gea_pkg::SHAFT_W-1:0] out_shaft_r;
  logic signed [gea_pkg::CUR_W-1:0]   out_cur_r;

  logic [gea_pkg::RATIO_W-1:0]        ratio_eff;
  gea_pkg::wrap_dir_t                 enc_dir;
  gea_pkg::wrap_dir_t                 shaft_dir;
  logic [gea_pkg::TURN_W-1:0]         turn_nxt;
  logic [DW-1:0]                      dividend;
  logic                               div_start;
  logic                               div_done;
  logic [DW-1:0]                      quotient;
  logic [DW-1:0]                      prev_shaft_ext;
  logic [gea_pkg::SHAFT_W-1:0]        shaft_nxt;
  logic                               in_fire;
  logic                               out_free;

  // a zero ratio behaves as one
  assign ratio_eff = (ratio_r == '0) ? gea_pkg::RATIO_W'(1) : ratio_r;

  // encoder wrap detection on the raw angle
  gea_wrap #(.W(gea_pkg::ANGLE_W)) u_enc_wrap (
    .now_val    (in_ch.angle_code),
    .before_val (prev_angle_r),
    .threshold  (thr_r),
    .dir        (enc_dir)
  );

  // turn index steps modulo the effective ratio
  always_comb begin
    case (enc_dir)
      gea_pkg::WRAP_FWD: begin
        turn_nxt = ({1'b0, turn_r} + 9'd1 >= {1'b0, ratio_eff}) ? '0 : turn_r + 8'd1;
      end
      gea_pkg::WRAP_BWD: begin
        turn_nxt = (turn_r == '0) ? ratio_eff - 8'd1 : turn_r - 8'd1;
      end
      default: begin
        turn_nxt = turn_r;
      end
    endcase
  end

  // total motor angle to divide
  assign dividend  = DW'(prev_angle_r) + DW'(turn_r) * CPT_DW;
  assign div_start = (state_r == ST_LOAD);

  gea_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (ratio_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // shaft wrap detection against the last shaft angle
  assign prev_shaft_ext = DW'(prev_shaft_r);

  gea_wrap #(.W(DW)) u_shaft_wrap (
    .now_val    (quotient),
    .before_val (prev_shaft_ext),
    .threshold  (thr_r),
    .dir        (shaft_dir)
  );

  // one-turn offset on the wrap sample, kept to the output width
  always_comb begin
    case (shaft_dir)
      gea_pkg::WRAP_FWD: shaft_nxt = quotient[gea_pkg::SHAFT_W-1:0] + CPT_SH;
      gea_pkg::WRAP_BWD: shaft_nxt = quotient[gea_pkg::SHAFT_W-1:0] - CPT_SH;
      default:           shaft_nxt = quotient[gea_pkg::SHAFT_W-1:0];
    endcase
  end

  assign in_fire  = in_ch.valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      thr_r        <= gea_pkg::WRAP_THRESHOLD_RESET;
      ratio_r      <= gea_pkg::RATIO_W'(1);
      prev_angle_r <= '0;
      turn_r       <= '0;
      prev_shaft_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != ST_POST)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          gea_pkg::REG_WRAP_THRESHOLD: begin
            thr_r <= cfg_data[gea_pkg::THR_W-1:0];
          end
          gea_pkg::REG_GEAR_RATIO: begin
            ratio_r <= cfg_data[gea_pkg::RATIO_W-1:0];
            turn_r  <= '0;
          end
          default: begin
          end
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            turn_r       <= turn_nxt;
            prev_angle_r <= in_ch.angle_code;
            cur_r        <= in_ch.current_code;
            state_r      <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_POST;
          end
        end
        ST_POST: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_shaft_r  <= shaft_nxt;
            out_cur_r    <= cur_r;
            prev_shaft_r <= quotient[gea_pkg::PREV_W-1:0];
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.shaft_angle   = out_shaft_r;
  assign out_ch.motor_current = out_cur_r;

endmodule

@@ dv/geared_encoder_angle_tracker_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// geared_encoder_angle_tracker_core_tb
// Self-checking bench for the geared encoder angle tracker.
// ----------------------------------------------------------------------------
// Feedback samples go in over a valid/ready channel with random gaps on both
// sides. A behavioral tracker follows every accepted sample, including turn
// counting and shaft wrap marking, and each result is checked against the
// oldest prediction. The run steps through several threshold and gear ratio
// settings, written between phases while the block is drained.
// ----------------------------------------------------------------------------
module geared_encoder_angle_tracker_core_tb;

  localparam int COUNTS = gea_pkg::ENCODER_COUNTS;

  typedef struct packed {
    logic        [gea_pkg::ANGLE_W-1:0] angle;
    logic signed [gea_pkg::CUR_W-1:0]   current;
  } sample_t;

  typedef struct packed {
    logic signed [gea_pkg::SHAFT_W-1:0] shaft;
    logic signed [gea_pkg::CUR_W-1:0]   current;
  } shaft_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [gea_pkg::CFG_W-1:0] cfg_data;
  logic                      gapless;

  gea_in_if  in_ch ();
  gea_out_if out_ch ();

  geared_encoder_angle_tracker_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sample_t       sample_q[$];
  shaft_result_t expected_shaft_q[$];
  int            mismatches;

  // tracker state mirrored from the block
  logic signed [gea_pkg::THR_W-1:0]   trk_threshold;
  logic        [gea_pkg::RATIO_W-1:0] trk_ratio;
  logic        [gea_pkg::TURN_W-1:0]  trk_turn;
  logic        [gea_pkg::ANGLE_W-1:0] trk_prev_angle;
  logic        [gea_pkg::PREV_W-1:0]  trk_prev_shaft;

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // +1 forward wrap, -1 backward wrap, 0 none; forward test wins
  function automatic int wrap_step(input int now, input int prior);
    if (now - prior < int'(trk_threshold)) return 1;
    if (prior - now < int'(trk_threshold)) return -1;
    return 0;
  endfunction

  function automatic shaft_result_t predict_shaft(input sample_t s);
    shaft_result_t r;
    int ratio, step, turn, quot, shaft;
    ratio = (trk_ratio == 0) ? 1 : int'(trk_ratio);
    turn  = int'(trk_turn);
    step  = wrap_step(int'(s.angle), int'(trk_prev_angle));
    if (step > 0) begin
      turn = (turn + 1 >= ratio) ? 0 : turn + 1;
    end else if (step < 0) begin
      turn = (turn == 0) ? ratio - 1 : turn - 1;
    end
    trk_turn       = turn[gea_pkg::TURN_W-1:0];
    trk_prev_angle = s.angle;
    quot  = (int'(s.angle) + COUNTS * int'(trk_turn)) / ratio;
    step  = wrap_step(quot, int'(trk_prev_shaft));
    trk_prev_shaft = quot[gea_pkg::PREV_W-1:0];
    shaft = quot + COUNTS * step;
    r.shaft   = shaft[gea_pkg::SHAFT_W-1:0];
    r.current = s.current;
    return r;
  endfunction

  // sample driver
  always @(posedge clk) begin : drive_samples
    sample_t s;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (sample_q.size() != 0 && (gapless || $urandom_range(99) >= 29)) begin
        s = sample_q.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.angle_code   <= s.angle;
        in_ch.current_code <= s.current;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(posedge clk) begin
    out_ch.ready <= gapless || ($urandom_range(99) >= 29);
  end

  // tracker model, config mirror and result check
  always @(posedge clk) begin : track_and_check
    shaft_result_t want;
    sample_t       s;
    if (!rst_n) begin
      trk_threshold  = gea_pkg::WRAP_THRESHOLD_RESET;
      trk_ratio      = 8'd1;
      trk_turn       = '0;
      trk_prev_angle = '0;
      trk_prev_shaft = '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_shaft_q.size() == 0) begin
          report_mismatch("unexpected result, shaft", int'(out_ch.shaft_angle), 0);
        end else begin
          want = expected_shaft_q.pop_front();
          if (out_ch.shaft_angle !== want.shaft)
            report_mismatch("shaft_angle", int'(out_ch.shaft_angle), int'(want.shaft));
          if (out_ch.motor_current !== want.current)
            report_mismatch("motor_current", int'(out_ch.motor_current),
                            int'(want.current));
        end
      end
      if (cfg_we) begin
        case (gea_pkg::cfg_reg_t'(cfg_index))
          gea_pkg::REG_WRAP_THRESHOLD: trk_threshold = cfg_data[gea_pkg::THR_W-1:0];
          gea_pkg::REG_GEAR_RATIO: begin
            trk_ratio = cfg_data[gea_pkg::RATIO_W-1:0];
            trk_turn  = '0;
          end
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        s.angle   = in_ch.angle_code;
        s.current = in_ch.current_code;
        expected_shaft_q.push_back(predict_shaft(s));
      end
    end
  end

  task automatic push_sample(input int angle, input int current);
    sample_t s;
    s.angle   = angle[gea_pkg::ANGLE_W-1:0];
    s.current = current[gea_pkg::CUR_W-1:0];
    sample_q.push_back(s);
  endtask

  task automatic write_reg(input gea_pkg::cfg_reg_t idx,
                           input logic [gea_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // block is idle once every queued item went in and every result came back;
  // checked away from the rising edge so that driver updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_ch.valid || expected_shaft_q.size() != 0);
  endtask

  // smooth rotation segments with random speed, plus some raw noise
  task automatic push_rotation(input int count);
    int angle, speed, seg_left, cur;
    bit noisy;
    angle    = $urandom_range(COUNTS - 1);
    seg_left = 0;
    noisy    = 1'b0;
    speed    = 0;
    repeat (count) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 4);
        noisy    = $urandom_range(99) < 15;
        speed    = int'($urandom_range(6000)) - 3000;
        if ($urandom_range(9) == 0) speed = int'($urandom_range(16)) - 8;
      end
      if (noisy) begin
        angle = $urandom_range(COUNTS - 1);
      end else begin
        angle = (angle + speed + int'($urandom_range(40)) - 20) & (COUNTS - 1);
      end
      case ($urandom_range(15))
        0:       cur = -32768;
        1:       cur = 32767;
        default: cur = int'($urandom);
      endcase
      push_sample(angle, cur);
      seg_left--;
    end
  endtask

  // stimulus
  initial begin
    int thr_set[8];
    int ratio_set[8];
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = gea_pkg::REG_WRAP_THRESHOLD;
    cfg_data     = '0;
    gapless      = 1'b0;
    mismatches   = 0;
    in_ch.valid        = 1'b0;
    in_ch.angle_code   = '0;
    in_ch.current_code = '0;
    out_ch.ready       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: field extremes, both wrap directions, threshold edges
    push_sample(0, 0);
    push_sample(8191, 32767);
    push_sample(0, -32768);
    push_sample(1200, -1);
    push_sample(7000, 1);
    push_sample(8, 0);
    push_sample(8191, 12345);
    push_sample(1198, -12345);
    wait_drained();

    // ratio 3: two forward turns up to the top turn index, then one backward turn
    write_reg(gea_pkg::REG_WRAP_THRESHOLD, gea_pkg::CFG_W'(-4096));
    write_reg(gea_pkg::REG_GEAR_RATIO, gea_pkg::CFG_W'(3));
    push_sample(0, 1);
    push_sample(3000, 2);
    push_sample(6000, 3);
    push_sample(1000, 4);
    push_sample(5000, 5);
    push_sample(1, 6);
    push_sample(4000, 7);
    push_sample(100, 8);
    push_sample(7000, 9);
    push_sample(3000, 10);
    wait_drained();

    // zero ratio acts as one; positive threshold where both tests hold
    write_reg(gea_pkg::REG_GEAR_RATIO, {6'b101010, 8'd0});
    write_reg(gea_pkg::REG_WRAP_THRESHOLD, gea_pkg::CFG_W'(100));
    push_sample(10, -2);
    push_sample(20, 2);
    push_sample(20, 0);
    push_sample(8191, -32768);
    wait_drained();

    // random phases over a spread of settings
    thr_set   = '{-6992, -8191, 0, -4096, -1, 300, 0, 0};
    ratio_set = '{1, 255, 5, 0, 2, 16, 0, 0};
    for (int p = 0; p < 8; p++) begin
      if (p >= 6) begin
        thr_set[p]   = -int'($urandom_range(8191));
        ratio_set[p] = $urandom_range(255, 1);
      end
      write_reg(gea_pkg::REG_WRAP_THRESHOLD, gea_pkg::CFG_W'(thr_set[p]));
      write_reg(gea_pkg::REG_GEAR_RATIO,
                {6'($urandom), ratio_set[p][gea_pkg::RATIO_W-1:0]});
      gapless <= (p == 2);
      push_rotation(144);
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS geared_encoder_angle_tracker_core");
    end else begin
      $display("FAIL geared_encoder_angle_tracker_core");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL geared_encoder_angle_tracker_core");
    $finish;
  end

endmodule

@@ files.f @@
src/gea_pkg.sv
src/gea_if.sv
src/gea_wrap.sv
src/gea_div.sv
src/geared_encoder_angle_tracker_core.sv
dv/geared_encoder_angle_tracker_core_tb.sv
